### design/pmle_pkg.sv
// ----------------------------------------------------------------------------
// pmle_pkg
// Shared types and constants of the Potts lattice engine: operation codes,
// register indexes, field widths and the controller state type.
// ----------------------------------------------------------------------------
package pmle_pkg;

    localparam int SIDE_DEF      = 64;
    localparam int PROB_BITS_DEF = 16;

    localparam int ROW_W   = 6;
    localparam int SPIN_W  = 5;
    localparam int CODE_W  = 4;
    localparam int PROP_W  = 4;
    localparam int RAND_W  = 16;
    localparam int PROB_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int DELTA_W = 4;
    localparam int SUM_W   = 14;

    localparam logic [CIDX_W-1:0] CFG_NUM_STATES = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_PROB_ONE   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_PROB_TWO   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_PROB_THREE = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PROB_FOUR  = 3'd4;

    localparam logic [SPIN_W-1:0] Q_MIN = 5'd2;
    localparam logic [SPIN_W-1:0] Q_MAX = 5'd16;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_MEASURE = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_WR_SET,
        ST_UP_RD0,
        ST_UP_RD1,
        ST_UP_RD2,
        ST_UP_EVAL,
        ST_MS_RUN,
        ST_MS_DRAIN,
        ST_MS_DONE
    } t_state;

endpackage

### design/potts_metropolis_lattice_engine_core.sv
// ----------------------------------------------------------------------------
// potts_metropolis_lattice_engine_core
// Periodic SIDE x SIDE q-state Potts lattice with site write, Metropolis
// update of the next raster site, and whole-lattice measure.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------
//  command  | i_op i_row i_col i_spin_value i_proposal_rand | i_start & !o_busy
//           | i_accept_rand                                 |
//  result   | o_site_row o_site_col o_spin_after o_accepted | o_valid, 1 cycle
//           | o_bond_change o_sweep_done o_unlike_bonds     |
//           | o_magnet_sum                                  |
//  config   | i_cfg_index i_cfg_data                        | i_cfg_we
//
// Write: passes ST_WR_MOD and ST_WR_SET. Update: the five spin reads go through
// the two read ports of the spin store in ST_UP_RD0..ST_UP_RD2, then ST_UP_EVAL.
// Measure: one site per cycle, then ST_MS_DRAIN and ST_MS_DONE. After reset the
// spin store is cleared one site a cycle with o_busy high. Results cannot be
// stalled; o_busy drops in the cycle that o_valid is shown.
// ----------------------------------------------------------------------------
module potts_metropolis_lattice_engine_core
    import pmle_pkg::*;
#(
    parameter int SIDE      = SIDE_DEF,
    parameter int PROB_BITS = PROB_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [1:0]               i_op,
    input  logic [ROW_W-1:0]         i_row,
    input  logic [ROW_W-1:0]         i_col,
    input  logic [SPIN_W-1:0]        i_spin_value,
    input  logic [PROP_W-1:0]        i_proposal_rand,
    input  logic [RAND_W-1:0]        i_accept_rand,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    output logic [ROW_W-1:0]         o_site_row,
    output logic [ROW_W-1:0]         o_site_col,
    output logic [SPIN_W-1:0]        o_spin_after,
    output logic                     o_accepted,
    output logic signed [DELTA_W-1:0] o_bond_change,
    output logic                     o_sweep_done,
    output logic [SUM_W-1:0]         o_unlike_bonds,
    output logic signed [SUM_W-1:0]  o_magnet_sum
);

    localparam int SITES = SIDE * SIDE;
    localparam int SW    = $clog2(SITES);
    localparam int CW    = $clog2(SIDE);
    localparam int PCMP  = (PROB_BITS < PROB_W) ? PROB_BITS : PROB_W;

    localparam logic [SW-1:0] A_SIDE   = SW'(SIDE);
    localparam logic [SW-1:0] A_SIDEM1 = SW'(SIDE - 1);
    localparam logic [SW-1:0] A_WRAP   = SW'(SITES - SIDE);
    localparam logic [SW-1:0] A_LAST   = SW'(SITES - 1);
    localparam logic [CW-1:0] C_LAST   = CW'(SIDE - 1);

    function automatic logic [CW-1:0] mod_side(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] t;
        t = v;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            if (int'(t) >= (SIDE << k)) begin
                t = t - ROW_W'(SIDE << k);
            end
        end
        return CW'(t);
    endfunction

    function automatic logic [ROW_W-1:0] to_field(input logic [CW-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[ROW_W-1:0];
    endfunction

    // control
    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic [SW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [SW-1:0] r_mpos, n_mpos;
    logic [CW-1:0] r_mrow, n_mrow;
    logic [CW-1:0] r_mcol, n_mcol;
    logic   r_dv, n_dv;
    logic   r_dfirst, n_dfirst;
    logic   r_dlast, n_dlast;

    // configuration
    logic [SPIN_W-1:0] r_num_states;
    logic [PROB_W-1:0] r_prob1, r_prob2, r_prob3, r_prob4;

    // payload
    t_op               r_op, n_op;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [ROW_W-1:0]  r_in_col, n_in_col;
    logic [SPIN_W-1:0] r_in_spin, n_in_spin;
    logic [PROP_W-1:0] r_prop, n_prop;
    logic [RAND_W-1:0] r_arand, n_arand;
    logic [CW-1:0]     r_wrow, n_wrow;
    logic [CW-1:0]     r_wcol, n_wcol;
    logic [CODE_W-1:0] r_old, n_old;
    logic [CODE_W-1:0] r_nl, n_nl;
    logic [CODE_W-1:0] r_nr, n_nr;
    logic [CODE_W-1:0] r_nu, n_nu;
    logic [CODE_W-1:0] r_prev, n_prev;
    logic [CODE_W-1:0] r_first, n_first;
    logic [SUM_W-1:0]  r_bonds, n_bonds;
    logic [SUM_W-1:0]  r_mag, n_mag;
    logic [ROW_W-1:0]  r_o_row, n_o_row;
    logic [ROW_W-1:0]  r_o_col, n_o_col;
    logic [SPIN_W-1:0] r_o_spin, n_o_spin;
    logic              r_o_acc, n_o_acc;
    logic [DELTA_W-1:0] r_o_delta, n_o_delta;
    logic              r_o_sweep, n_o_sweep;
    logic [SUM_W-1:0]  r_o_bonds, n_o_bonds;
    logic [SUM_W-1:0]  r_o_mag, n_o_mag;

    // memory port
    logic              m_we;
    logic [SW-1:0]     m_waddr;
    logic [CODE_W-1:0] m_wdata;
    logic [SW-1:0]     m_ra;
    logic [SW-1:0]     m_rb;
    logic [CODE_W-1:0] m_da;
    logic [CODE_W-1:0] m_db;

    pmle_spin_ram #(
        .DEPTH (SITES),
        .AW    (SW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (m_we),
        .i_waddr   (m_waddr),
        .i_wdata   (m_wdata),
        .i_raddr_a (m_ra),
        .i_raddr_b (m_rb),
        .o_rdata_a (m_da),
        .o_rdata_b (m_db)
    );

    // update evaluation
    logic [SPIN_W-1:0] q_eff;
    logic [CODE_W-1:0] q_m1;
    logic [CODE_W-1:0] p_lo;
    logic [CODE_W-1:0] p_cl;
    logic [CODE_W-1:0] nw;
    logic [2:0]        cnt_new;
    logic [2:0]        cnt_old;
    logic [DELTA_W-1:0] delta;
    logic [PROB_W-1:0] prob_sel;
    logic              acc;
    logic [SW-1:0]     a_left, a_right, a_up, a_down, a_mdown;
    logic [SPIN_W-1:0] ws_lo;
    logic [SPIN_W-1:0] ws;
    logic [1:0]        b_inc;

    always_comb begin
        if (r_num_states < Q_MIN) begin
            q_eff = Q_MIN;
        end else if (r_num_states > Q_MAX) begin
            q_eff = Q_MAX;
        end else begin
            q_eff = r_num_states;
        end
        q_m1 = CODE_W'(q_eff - 5'd1);
        p_lo = (r_prop == '0) ? 4'd1 : r_prop;
        p_cl = (p_lo > q_m1) ? q_m1 : p_lo;
        nw   = (p_cl - 4'd1 == r_old) ? q_m1 : (p_cl - 4'd1);
        cnt_new = 3'(nw != r_nl) + 3'(nw != r_nr) + 3'(nw != r_nu) + 3'(nw != m_da);
        cnt_old = 3'(r_old != r_nl) + 3'(r_old != r_nr) + 3'(r_old != r_nu)
                + 3'(r_old != m_da);
        delta = {1'b0, cnt_new} - {1'b0, cnt_old};
        unique case (delta[2:0])
            3'd1:    prob_sel = r_prob1;
            3'd2:    prob_sel = r_prob2;
            3'd3:    prob_sel = r_prob3;
            3'd4:    prob_sel = r_prob4;
            default: prob_sel = '0;
        endcase
        if (delta[DELTA_W-1] || delta == '0) begin
            acc = 1'b1;
        end else begin
            acc = prob_sel[PCMP-1:0] > r_arand[PCMP-1:0];
        end

        a_left  = (r_col == '0)     ? r_pos + A_SIDEM1 : r_pos - SW'(1);
        a_right = (r_col == C_LAST) ? r_pos - A_SIDEM1 : r_pos + SW'(1);
        a_up    = (r_row == '0)     ? r_pos + A_WRAP   : r_pos - A_SIDE;
        a_down  = (r_row == C_LAST) ? r_pos - A_WRAP   : r_pos + A_SIDE;
        a_mdown = (r_mrow == C_LAST) ? r_mpos - A_WRAP : r_mpos + A_SIDE;

        ws_lo = (r_in_spin == '0) ? 5'd1 : r_in_spin;
        ws    = (ws_lo > q_eff) ? q_eff : ws_lo;

        b_inc = 2'(m_da != m_db) + 2'(!r_dfirst && (m_da != r_prev))
              + 2'(r_dlast && (m_da != r_first));
    end

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_clr    = r_clr;
        n_pos    = r_pos;
        n_row    = r_row;
        n_col    = r_col;
        n_mpos   = r_mpos;
        n_mrow   = r_mrow;
        n_mcol   = r_mcol;
        n_dv     = 1'b0;
        n_dfirst = r_dfirst;
        n_dlast  = r_dlast;
        n_op     = r_op;
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        n_in_spin = r_in_spin;
        n_prop   = r_prop;
        n_arand  = r_arand;
        n_wrow   = r_wrow;
        n_wcol   = r_wcol;
        n_old    = r_old;
        n_nl     = r_nl;
        n_nr     = r_nr;
        n_nu     = r_nu;
        n_prev   = r_prev;
        n_first  = r_first;
        n_bonds  = r_bonds;
        n_mag    = r_mag;
        n_o_row  = r_o_row;
        n_o_col  = r_o_col;
        n_o_spin = r_o_spin;
        n_o_acc  = r_o_acc;
        n_o_delta = r_o_delta;
        n_o_sweep = r_o_sweep;
        n_o_bonds = r_o_bonds;
        n_o_mag  = r_o_mag;
        m_we     = 1'b0;
        m_waddr  = r_pos;
        m_wdata  = '0;
        m_ra     = r_pos;
        m_rb     = a_left;

        // accumulate measure data in the cycle after each read
        if (r_dv) begin
            n_bonds = r_bonds + SUM_W'(b_inc);
            n_mag   = (m_da == '0) ? r_mag - SUM_W'(1) : r_mag + SUM_W'(1);
            n_prev  = m_da;
            if (r_dfirst) begin
                n_first = m_da;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                n_clr   = r_clr + SW'(1);
                if (r_clr == A_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_op      = t_op'(i_op);
                    n_in_row  = i_row;
                    n_in_col  = i_col;
                    n_in_spin = i_spin_value;
                    n_prop    = i_proposal_rand;
                    n_arand   = i_accept_rand;
                    unique case (t_op'(i_op))
                        OP_WRITE:   n_state = ST_WR_MOD;
                        OP_UPDATE:  n_state = ST_UP_RD0;
                        OP_MEASURE: begin
                            n_state = ST_MS_RUN;
                            n_mpos  = '0;
                            n_mrow  = '0;
                            n_mcol  = '0;
                            n_bonds = '0;
                            n_mag   = '0;
                        end
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WR_MOD: begin
                n_wrow  = mod_side(r_in_row);
                n_wcol  = mod_side(r_in_col);
                n_state = ST_WR_SET;
            end
            ST_WR_SET: begin
                m_we      = 1'b1;
                m_waddr   = SW'(SW'(r_wrow) * A_SIDE) + SW'(r_wcol);
                m_wdata   = CODE_W'(ws - 5'd1);
                n_valid   = 1'b1;
                n_o_row   = to_field(r_wrow);
                n_o_col   = to_field(r_wcol);
                n_o_spin  = ws;
                n_o_acc   = 1'b0;
                n_o_delta = '0;
                n_o_sweep = 1'b0;
                n_o_bonds = '0;
                n_o_mag   = '0;
                n_state   = ST_IDLE;
            end
            ST_UP_RD0: begin
                m_ra    = r_pos;
                m_rb    = a_left;
                n_state = ST_UP_RD1;
            end
            ST_UP_RD1: begin
                n_old   = m_da;
                n_nl    = m_db;
                m_ra    = a_right;
                m_rb    = a_up;
                n_state = ST_UP_RD2;
            end
            ST_UP_RD2: begin
                n_nr    = m_da;
                n_nu    = m_db;
                m_ra    = a_down;
                n_state = ST_UP_EVAL;
            end
            ST_UP_EVAL: begin
                m_we      = acc;
                m_waddr   = r_pos;
                m_wdata   = nw;
                n_valid   = 1'b1;
                n_o_row   = to_field(r_row);
                n_o_col   = to_field(r_col);
                n_o_spin  = acc ? ({1'b0, nw} + 5'd1) : ({1'b0, r_old} + 5'd1);
                n_o_acc   = acc;
                n_o_delta = delta;
                n_o_sweep = (r_pos == A_LAST);
                n_o_bonds = '0;
                n_o_mag   = '0;
                if (r_pos == A_LAST) begin
                    n_pos = '0;
                    n_row = '0;
                    n_col = '0;
                end else begin
                    n_pos = r_pos + SW'(1);
                    if (r_col == C_LAST) begin
                        n_col = '0;
                        n_row = r_row + CW'(1);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
                n_state = ST_IDLE;
            end
            ST_MS_RUN: begin
                m_ra     = r_mpos;
                m_rb     = a_mdown;
                n_dv     = 1'b1;
                n_dfirst = (r_mcol == '0);
                n_dlast  = (r_mcol == C_LAST);
                n_mpos   = r_mpos + SW'(1);
                if (r_mcol == C_LAST) begin
                    n_mcol = '0;
                    n_mrow = r_mrow + CW'(1);
                end else begin
                    n_mcol = r_mcol + CW'(1);
                end
                if (r_mpos == A_LAST) begin
                    n_state = ST_MS_DRAIN;
                end
            end
            ST_MS_DRAIN: begin
                n_state = ST_MS_DONE;
            end
            ST_MS_DONE: begin
                n_valid   = 1'b1;
                n_o_row   = '0;
                n_o_col   = '0;
                n_o_spin  = '0;
                n_o_acc   = 1'b0;
                n_o_delta = '0;
                n_o_sweep = 1'b0;
                n_o_bonds = r_bonds;
                n_o_mag   = r_mag;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_valid      <= 1'b0;
            r_clr        <= '0;
            r_pos        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_mpos       <= '0;
            r_mrow       <= '0;
            r_mcol       <= '0;
            r_dv         <= 1'b0;
            r_dfirst     <= 1'b0;
            r_dlast      <= 1'b0;
            r_num_states <= Q_MIN;
            r_prob1      <= '0;
            r_prob2      <= '0;
            r_prob3      <= '0;
            r_prob4      <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_clr    <= n_clr;
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_col    <= n_col;
            r_mpos   <= n_mpos;
            r_mrow   <= n_mrow;
            r_mcol   <= n_mcol;
            r_dv     <= n_dv;
            r_dfirst <= n_dfirst;
            r_dlast  <= n_dlast;
            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    CFG_NUM_STATES: r_num_states <= i_cfg_data[SPIN_W-1:0];
                    CFG_PROB_ONE:   r_prob1      <= i_cfg_data;
                    CFG_PROB_TWO:   r_prob2      <= i_cfg_data;
                    CFG_PROB_THREE: r_prob3      <= i_cfg_data;
                    CFG_PROB_FOUR:  r_prob4      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_in_row  <= n_in_row;
        r_in_col  <= n_in_col;
        r_in_spin <= n_in_spin;
        r_prop    <= n_prop;
        r_arand   <= n_arand;
        r_wrow    <= n_wrow;
        r_wcol    <= n_wcol;
        r_old     <= n_old;
        r_nl      <= n_nl;
        r_nr      <= n_nr;
        r_nu      <= n_nu;
        r_prev    <= n_prev;
        r_first   <= n_first;
        r_bonds   <= n_bonds;
        r_mag     <= n_mag;
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_spin  <= n_o_spin;
        r_o_acc   <= n_o_acc;
        r_o_delta <= n_o_delta;
        r_o_sweep <= n_o_sweep;
        r_o_bonds <= n_o_bonds;
        r_o_mag   <= n_o_mag;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_site_row     = r_o_row;
    assign o_site_col     = r_o_col;
    assign o_spin_after   = r_o_spin;
    assign o_accepted     = r_o_acc;
    assign o_bond_change  = $signed(r_o_delta);
    assign o_sweep_done   = r_o_sweep;
    assign o_unlike_bonds = r_o_bonds;
    assign o_magnet_sum   = $signed(r_o_mag);

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held longer than one cycle");

    a_no_write_in_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MS_RUN || r_state == ST_MS_DRAIN || r_state == ST_MS_DONE)
        |-> !m_we)
        else $error("spin store written during measure");

    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= A_LAST)
        else $error("sweep position beyond lattice");

    a_nonpositive_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_op == OP_UPDATE && (r_o_delta[DELTA_W-1] || r_o_delta == '0))
        |-> r_o_acc)
        else $error("non-positive bond change rejected");

    a_sweep_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_o_sweep) |-> (r_pos == '0))
        else $error("sweep end without wrap of position");
`endif

endmodule

### design/pmle_spin_ram.sv
// ----------------------------------------------------------------------------
// pmle_spin_ram
// Spin store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module pmle_spin_ram
    import pmle_pkg::*;
#(
    parameter int DEPTH = SIDE_DEF * SIDE_DEF,
    parameter int AW    = $clog2(SIDE_DEF * SIDE_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CODE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [CODE_W-1:0] o_rdata_a,
    output logic [CODE_W-1:0] o_rdata_b
);

    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rdata_a;
    logic [CODE_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
